@@ hdl/sorted_priority_queue_core_assert.svh @@
// assertion macros used by the checker of the queue core
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk and idle while rst_n is low
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and idle while rst_n is low
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/spq_pkg.sv @@
package spq_pkg;

    localparam int unsigned DEPTH_DEF = 8;
    localparam int unsigned PRIO_W    = 8;
    localparam int unsigned TAG_W     = 16;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned OCC_W     = 4;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t entry;
    } cell_ctrl_t;

endpackage

@@ hdl/spq_if.sv @@
interface spq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [spq_pkg::PRIO_W-1:0]  prio;
    logic [spq_pkg::TAG_W-1:0]   payload;

    modport source (output valid, output func, output prio, output payload, input ready);
    modport sink   (input valid, input func, input prio, input payload, output ready);
endinterface

interface spq_out_if;
    logic                          valid;
    logic                          ready;
    logic                          out_valid;
    logic [spq_pkg::PRIO_W-1:0]    out_prio;
    logic [spq_pkg::TAG_W-1:0]     out_payload;
    logic [spq_pkg::STATUS_W-1:0]  status;
    logic [spq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, output out_valid, output out_prio, output out_payload,
                    output status, output occupancy, input ready);
    modport sink   (input valid, input out_valid, input out_prio, input out_payload,
                    input status, input occupancy, output ready);
endinterface

@@ hdl/sorted_priority_queue_core.sv @@
// sorted priority queue core
// in_ch carries one operation per transaction: func selects push or pop, prio and
// payload give the entry for a push (ignored for a pop). out_ch returns exactly one
// result transaction per operation: out_valid, out_prio and out_payload carry the
// popped entry (all zero otherwise), status reports done, push rejected full or pop
// rejected empty, and occupancy gives the entry count after the operation (low 4 bits).
// the result is registered and appears on out_ch in the cycle after the input transaction
// throughput: one operation per cycle unless out_ch stalls; every cell compares its own
// priority against the broadcast one and shifts in the same cycle, so the row sets the rate
// lowest priority value is served first; equal priorities leave in arrival order
// a single output register decouples the channels: in_ch.ready is high while that
// register is empty or being drained, so a stalled receiver holds the pending result
// and stops new operations after one
// reset clears the count and the valid flag of the output register; cell contents
// are not cleared and only cells below the count are ever read
module sorted_priority_queue_core #(
    parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_in_if.sink    in_ch,
    spq_out_if.source out_ch
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // entry count
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // output register
    logic                         res_valid_reg;
    logic                         res_valid_next;
    logic                         res_hit_reg;
    logic                         res_hit_next;
    spq_pkg::entry_t              res_entry_reg;
    spq_pkg::entry_t              res_entry_next;
    spq_pkg::status_t             res_status_reg;
    spq_pkg::status_t             res_status_next;
    logic [spq_pkg::OCC_W-1:0]    res_occ_reg;
    logic [spq_pkg::OCC_W-1:0]    res_occ_next;

    logic                         accept;
    logic                         is_pop;
    logic                         full;
    logic                         empty;
    logic [CNT_W+spq_pkg::OCC_W-1:0] occ_wide;
    spq_pkg::cell_ctrl_t          ctrl;

    // cell row
    spq_pkg::entry_t              cell_data [DEPTH];
    logic                         cell_gt   [DEPTH];

    // accept while the output register is free or drains this cycle
    assign in_ch.ready = !res_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_pop      = (in_ch.func == spq_pkg::FUNC_POP);
    assign full        = (count_reg == CNT_W'(DEPTH));
    assign empty       = (count_reg == '0);

    // only accepted operations that are not rejected touch the cells
    assign ctrl.push       = accept && !is_pop && !full;
    assign ctrl.pop        = accept && is_pop && !empty;
    assign ctrl.entry.prio = in_ch.prio;
    assign ctrl.entry.tag  = in_ch.payload;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            spq_pkg::entry_t left_data;
            logic            left_gt;
            spq_pkg::entry_t right_data;

            if (i == 0)
            begin : g_head
                // head cell: nothing ranks ahead of it
                assign left_data = ctrl.entry;
                assign left_gt   = 1'b0;
            end
            else
            begin : g_body
                assign left_data = cell_data[i-1];
                assign left_gt   = cell_gt[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                // tail cell keeps its value on a pop; it is vacant afterward
                assign right_data = cell_data[i];
            end
            else
            begin : g_mid
                assign right_data = cell_data[i+1];
            end

            spq_cell u_cell (
                .clk     (clk),
                .ctrl    (ctrl),
                .vacant  (count_reg <= CNT_W'(i)),
                .left    (left_data),
                .left_gt (left_gt),
                .right   (right_data),
                .data    (cell_data[i]),
                .gt      (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // occupancy is reported modulo 16
    assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, count_next};

    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_hit_next    = res_hit_reg;
        res_entry_next  = res_entry_reg;
        res_status_next = res_status_reg;
        res_occ_next    = res_occ_reg;
        if (res_valid_reg && out_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (accept)
        begin
            res_valid_next  = 1'b1;
            res_hit_next    = ctrl.pop;
            res_entry_next  = ctrl.pop ? cell_data[0] : '0;
            res_occ_next    = occ_wide[spq_pkg::OCC_W-1:0];
            if (!is_pop && full)
            begin
                res_status_next = spq_pkg::ST_FULL;
            end
            else if (is_pop && empty)
            begin
                res_status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                res_status_next = spq_pkg::ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_hit_reg    <= res_hit_next;
        res_entry_reg  <= res_entry_next;
        res_status_reg <= res_status_next;
        res_occ_reg    <= res_occ_next;
    end

    assign out_ch.valid       = res_valid_reg;
    assign out_ch.out_valid   = res_hit_reg;
    assign out_ch.out_prio    = res_entry_reg.prio;
    assign out_ch.out_payload = res_entry_reg.tag;
    assign out_ch.status      = res_status_reg;
    assign out_ch.occupancy   = res_occ_reg;

endmodule

@@ hdl/spq_cell.sv @@
module spq_cell (
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic                vacant,
    input  spq_pkg::entry_t     left,
    input  logic                left_gt,
    input  spq_pkg::entry_t     right,
    output spq_pkg::entry_t     data,
    output logic                gt
);

    spq_pkg::entry_t data_reg;
    spq_pkg::entry_t data_next;

    // occupied and ranked behind the incoming entry
    assign gt   = !vacant && (data_reg.prio > ctrl.entry.prio);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push)
        begin
            if (left_gt)
            begin
                data_next = left;
            end
            else if (gt || vacant)
            begin
                data_next = ctrl.entry;
            end
        end
        else if (ctrl.pop)
        begin
            data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ hdl/spq_checker.sv @@
`include "sorted_priority_queue_core_assert.svh"

module spq_checker #(
    parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_ch_valid,
    input logic                         out_ch_ready,
    input logic                         out_valid,
    input logic [spq_pkg::PRIO_W-1:0]   out_prio,
    input logic [spq_pkg::TAG_W-1:0]    out_payload,
    input logic [spq_pkg::STATUS_W-1:0] status,
    input logic [spq_pkg::OCC_W-1:0]    occupancy
);

    localparam logic [spq_pkg::OCC_W-1:0] DEPTH_OCC = spq_pkg::OCC_W'(DEPTH);

    // a stalled result holds until taken
    `SPQ_ASSERT_NEXT(a_out_hold, out_ch_valid && !out_ch_ready,
        out_ch_valid && $stable(out_valid) && $stable(out_prio) && $stable(out_payload)
        && $stable(status) && $stable(occupancy), "stalled result changed")

    // a returned entry only comes with a completed pop
    `SPQ_ASSERT_NOW(a_hit_done, out_ch_valid && out_valid,
        status == spq_pkg::ST_DONE, "returned entry with a rejection status")

    // results without an entry carry zero fields
    `SPQ_ASSERT_NOW(a_miss_zero, out_ch_valid && !out_valid,
        out_prio == '0 && out_payload == '0, "nonzero fields without an entry")

    // rejections report the bound they hit
    `SPQ_ASSERT_NOW(a_reject_occ,
        out_ch_valid && (status == spq_pkg::ST_FULL || status == spq_pkg::ST_EMPTY),
        (status == spq_pkg::ST_FULL && occupancy == DEPTH_OCC)
        || (status == spq_pkg::ST_EMPTY && occupancy == '0),
        "rejection with wrong occupancy")

    // every accepted operation leaves a result on the next cycle
    logic in_seen;
    assign in_seen = in_valid && in_ready;
    `SPQ_ASSERT_NEXT(a_accept_result, in_seen, out_ch_valid, "accepted operation gave no result")

endmodule

bind sorted_priority_queue_core spq_checker #(
    .DEPTH (DEPTH)
) u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_ch_valid (out_ch.valid),
    .out_ch_ready (out_ch.ready),
    .out_valid    (out_ch.out_valid),
    .out_prio     (out_ch.out_prio),
    .out_payload  (out_ch.out_payload),
    .status       (out_ch.status),
    .occupancy    (out_ch.occupancy)
);

@@ tb/tb_sorted_priority_queue_core.sv @@
module tb_sorted_priority_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QDEPTH = spq_pkg::DEPTH_DEF;

    // one expected result transaction on out_ch
    typedef struct {
        logic                         out_valid;
        logic [spq_pkg::PRIO_W-1:0]   prio;
        logic [spq_pkg::TAG_W-1:0]    payload;
        spq_pkg::status_t             status;
        logic [spq_pkg::OCC_W-1:0]    occupancy;
    } pq_result_t;

    logic clk;
    logic rst_n;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue_core #(
        .DEPTH (QDEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // shadow copy of the sorted queue, head at index 0
    logic [spq_pkg::PRIO_W-1:0] shadow_prio [QDEPTH];
    logic [spq_pkg::TAG_W-1:0]  shadow_tag  [QDEPTH];
    int unsigned                shadow_count;

    // results still owed by the block, oldest first
    pq_result_t pending_results [$];

    int error_count;
    int src_idle_pct;
    int sink_stall_pct;
    logic sink_hold;

    // free running clock, 10 ns period
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("** sorted_priority_queue_core: FAILED **");
        $finish;
    end

    // apply one operation to the shadow queue and return what the block must report
    function automatic pq_result_t predict_queue_op(input spq_pkg::func_t op,
                                                    input logic [spq_pkg::PRIO_W-1:0] p,
                                                    input logic [spq_pkg::TAG_W-1:0] t);
        pq_result_t  r;
        int unsigned pos;
        r.out_valid = 1'b0;
        r.prio      = '0;
        r.payload   = '0;
        r.status    = spq_pkg::ST_DONE;
        if (op == spq_pkg::FUNC_PUSH)
        begin
            if (shadow_count >= QDEPTH)
                r.status = spq_pkg::ST_FULL;
            else
            begin
                // walk down from the tail past every entry with a strictly higher value
                pos = shadow_count;
                while (pos > 0 && shadow_prio[pos-1] > p)
                begin
                    shadow_prio[pos] = shadow_prio[pos-1];
                    shadow_tag[pos]  = shadow_tag[pos-1];
                    pos--;
                end
                shadow_prio[pos] = p;
                shadow_tag[pos]  = t;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                r.status = spq_pkg::ST_EMPTY;
            else
            begin
                r.out_valid = 1'b1;
                r.prio      = shadow_prio[0];
                r.payload   = shadow_tag[0];
                for (int i = 1; i < shadow_count; i++)
                begin
                    shadow_prio[i-1] = shadow_prio[i];
                    shadow_tag[i-1]  = shadow_tag[i];
                end
                shadow_count--;
            end
        end
        r.occupancy = shadow_count[spq_pkg::OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // input monitor and result checker share one process: the prediction of a
    // transaction accepted at this edge is queued before the output is checked
    always @(posedge clk)
    begin
        pq_result_t want;
        if (rst_n === 1'b1)
        begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                pending_results.push_back(predict_queue_op(spq_pkg::func_t'(in_ch.func),
                                                           in_ch.prio, in_ch.payload));
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                begin
                    want = pending_results.pop_front();
                    if (out_ch.out_valid !== want.out_valid)
                        report_mismatch($sformatf("out_valid %b, expected %b",
                                                  out_ch.out_valid, want.out_valid));
                    if (out_ch.out_prio !== want.prio)
                        report_mismatch($sformatf("out_prio %0d, expected %0d",
                                                  out_ch.out_prio, want.prio));
                    if (out_ch.out_payload !== want.payload)
                        report_mismatch($sformatf("out_payload %h, expected %h",
                                                  out_ch.out_payload, want.payload));
                    if (out_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  out_ch.status, want.status));
                    if (out_ch.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy %0d, expected %0d",
                                                  out_ch.occupancy, want.occupancy));
                end
            end
        end
    end

    // receiver: random stalls, plus a forced hold-off while sink_hold is set
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= !sink_hold && ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // offer one operation, leaving valid high after acceptance so that a
    // back-to-back transaction never lowers and raises it in one step
    task automatic send_op(input spq_pkg::func_t op, input logic [spq_pkg::PRIO_W-1:0] p,
                           input logic [spq_pkg::TAG_W-1:0] t);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.func    <= op;
        in_ch.prio    <= p;
        in_ch.payload <= t;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
    endtask

    // sender goes quiet until every owed result has come back
    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        // result register is one deep; the extra wait below covers it
        repeat (4) @(posedge clk);
    endtask

    // priority drawn from a tiny range in 35 percent of draws so that ties are common
    function automatic logic [spq_pkg::PRIO_W-1:0] rand_prio();
        if ($urandom_range(0, 99) < 35)
            return spq_pkg::PRIO_W'($urandom_range(0, 3));
        return spq_pkg::PRIO_W'($urandom_range(0, 255));
    endfunction

    function automatic spq_pkg::func_t rand_func(input int push_pct);
        return ($urandom_range(0, 99) < push_pct) ? spq_pkg::FUNC_PUSH : spq_pkg::FUNC_POP;
    endfunction

    // extremes of every field, empty and full rejection, arrival order of ties
    task automatic test_directed();
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        send_op(spq_pkg::FUNC_POP,  8'd0,   16'h0000);   // pop right after reset
        send_op(spq_pkg::FUNC_PUSH, 8'd255, 16'hFFFF);
        send_op(spq_pkg::FUNC_PUSH, 8'd0,   16'h0000);
        send_op(spq_pkg::FUNC_PUSH, 8'd128, 16'h1234);
        send_op(spq_pkg::FUNC_PUSH, 8'd128, 16'h4321);   // ties must leave in arrival order
        send_op(spq_pkg::FUNC_PUSH, 8'd128, 16'hAAAA);
        send_op(spq_pkg::FUNC_PUSH, 8'd0,   16'h5555);
        send_op(spq_pkg::FUNC_PUSH, 8'd255, 16'h0001);
        send_op(spq_pkg::FUNC_PUSH, 8'd7,   16'h8000);   // queue now full
        send_op(spq_pkg::FUNC_PUSH, 8'd0,   16'hFFFF);   // rejected, even with the best priority
        repeat (QDEPTH) send_op(spq_pkg::FUNC_POP, 8'd255, 16'hFFFF);
        send_op(spq_pkg::FUNC_POP,  8'd255, 16'hFFFF);   // rejected, empty again
        send_op(spq_pkg::FUNC_PUSH, 8'd42,  16'hC3C3);
        send_op(spq_pkg::FUNC_POP,  8'd0,   16'h0000);
        wait_all_results();
    endtask

    // random mix in runs that lean toward filling, balance or draining
    task automatic test_random_mix(input int n_items, input int src_pct, input int sink_pct);
        int push_pct;
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
        push_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 16 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
            end
            send_op(rand_func(push_pct), rand_prio(),
                    spq_pkg::TAG_W'($urandom_range(0, 65535)));
        end
        wait_all_results();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so the result register fills and the input stalls
    task automatic test_output_hold_off();
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (300) @(posedge clk);
                sink_hold <= 1'b0;
            end
            begin
                for (int i = 0; i < 40; i++)
                    send_op(rand_func(60), rand_prio(),
                            spq_pkg::TAG_W'($urandom_range(0, 65535)));
            end
        join
        wait_all_results();
    endtask

    initial
    begin
        error_count    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        shadow_count   = 0;
        foreach (shadow_prio[i])
        begin
            shadow_prio[i] = '0;
            shadow_tag[i]  = '0;
        end
        sink_hold     <= 1'b0;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.func    <= spq_pkg::FUNC_PUSH;
        in_ch.prio    <= '0;
        in_ch.payload <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(420, 0, 0);
        test_random_mix(420, 58, 0);
        test_random_mix(420, 0, 58);
        test_random_mix(420, 23, 23);
        test_output_hold_off();

        // leftover expectations mean results never arrived
        while (pending_results.size() != 0)
        begin
            void'(pending_results.pop_front());
            report_mismatch("expected result never arrived");
        end
        if (error_count == 0)
            $display("** sorted_priority_queue_core: PASSED **");
        else
            $display("** sorted_priority_queue_core: FAILED **");
        $finish;
    end

endmodule
